// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/skrd_pkg.sv -----
// Shared types and constants for the spike kernel rate decoder.
package skrd_pkg;

    localparam int TIME_W         = 32;
    localparam int WINDOW_W       = 24;
    localparam int RATE_W         = 40;
    localparam int KERNEL_W       = 24;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 24;
    localparam int TABLE_DEPTH_DEF    = 1024;
    localparam int TIME_FRAC_BITS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 1'b1;

    localparam logic [WINDOW_W-1:0]        WINDOW_RESET = 24'd65536;
    localparam logic signed [KERNEL_W-1:0] BOX_Q16      = 24'sd65536;
    localparam logic signed [RATE_W-1:0]   SUM_MAX      = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0]   SUM_MIN      = {1'b1, {(RATE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        KM_BOX   = 3'd0,
        KM_ALPHA = 3'd1,
        KM_EXP   = 3'd2,
        KM_DEXP  = 3'd3,
        KM_DERIV = 3'd4
    } kernel_mode_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic count;
        logic in_table;
    } s1_t;

endpackage

// ----- rtl/core/skrd_front.sv -----
// Front stage: delay, window check, table index and the input register.
module skrd_front #(
    parameter int TABLE_DEPTH    = skrd_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_FRAC_BITS = skrd_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [skrd_pkg::TIME_W-1:0]         query_time,
    input  logic [skrd_pkg::TIME_W-1:0]         spike_time,
    input  logic                                spike_valid,
    input  logic                                last_spike,
    input  logic [skrd_pkg::WINDOW_W-1:0]       window,
    input  logic                                s1_hold,
    output logic [$clog2(TABLE_DEPTH)-1:0]      rom_addr,
    output logic                                rom_load,
    output skrd_pkg::s1_t                       s1
);
    import skrd_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W  = TIME_W + DEPTH_W;

    logic [TIME_W-1:0] delay;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] idx_full;
    logic              in_table;
    logic              count;
    s1_t               s1_reg;
    s1_t               s1_next;

    assign delay    = query_time - spike_time;
    assign prod     = PROD_W'(delay) * PROD_W'(TABLE_DEPTH);
    assign idx_full = prod >> TIME_FRAC_BITS;
    assign in_table = idx_full < PROD_W'(TABLE_DEPTH);
    assign count    = spike_valid && (spike_time <= query_time)
                      && (delay <= TIME_W'(window));

    assign in_stall = s1_reg.valid && s1_hold;
    assign rom_load = !in_stall;
    assign rom_addr = in_table ? idx_full[IDX_W-1:0] : '0;

    always_comb
    begin
        s1_next = s1_reg;
        if (!in_stall)
        begin
            s1_next.valid    = in_valid;
            s1_next.last     = last_spike;
            s1_next.count    = count;
            s1_next.in_table = in_table;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

// ----- rtl/core/skrd_kernel_rom.sv -----
// Kernel tables for alpha, exponential, double exponential and derivative.
module skrd_kernel_rom #(
    parameter int TABLE_DEPTH = skrd_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  skrd_pkg::kernel_mode_t                mode,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        addr,
    output logic signed [skrd_pkg::KERNEL_W-1:0]  rom_data
);
    import skrd_pkg::*;

    localparam logic [63:0] MASK32   = 64'hFFFF_FFFF;
    localparam logic [63:0] ONE_Q32  = 64'd4294967296;
    localparam logic [63:0] EINV_Q32 = 64'd1580030169;
    localparam logic [63:0] E_Q32    = 64'd11674931555;
    localparam logic [63:0] NORM_Q32 = 64'd9090447472;

    typedef logic signed [KERNEL_W-1:0] rom_t [TABLE_DEPTH];

    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        ah = a >> 32;
        al = a & MASK32;
        bh = b >> 32;
        bl = b & MASK32;
        return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] y);
        logic [63:0]        n;
        logic [63:0]        f;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] acc;
        n    = y >> 32;
        f    = y & MASK32;
        term = ONE_Q32;
        acc  = $signed(ONE_Q32);
        for (int Kn = 1; Kn <= 20; Kn++)
        begin
            term = mul_q32(term, f) / 64'(Kn);
            if (Kn[0])
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = '0;
        r = $unsigned(acc);
        for (int Rn = 0; Rn < 64; Rn++)
        begin
            if (n != 0 && r != 0)
            begin
                r = mul_q32(r, EINV_Q32);
                n = n - 64'd1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [KERNEL_W-1:0] kernel_entry(
        input kernel_mode_t km,
        input logic [63:0]  idx
    );
        logic [63:0]        x10;
        logic [63:0]        x40;
        logic [63:0]        e10;
        logic [63:0]        e40;
        logic [63:0]        pos;
        logic [63:0]        neg;
        logic signed [63:0] v;
        x10 = ((64'd10 * idx) << 32) / 64'(TABLE_DEPTH);
        x40 = ((64'd40 * idx) << 32) / 64'(TABLE_DEPTH);
        e10 = exp_neg(x10);
        e40 = exp_neg(x40);
        pos = 64'd40 * e40;
        neg = 64'd10 * e10;
        case (km)
            KM_ALPHA: v = $signed(mul_q32(mul_q32(x10, e10), E_Q32));
            KM_EXP:   v = $signed(e10);
            KM_DEXP:  v = (e10 >= e40) ? $signed(mul_q32(e10 - e40, NORM_Q32)) : '0;
            KM_DERIV:
            begin
                if (pos >= neg)
                    v = $signed(mul_q32(pos - neg, NORM_Q32));
                else
                    v = -$signed(mul_q32(neg - pos, NORM_Q32));
            end
            default:  v = '0;
        endcase
        v = (v + 64'sd32768) >>> 16;
        return KERNEL_W'(v);
    endfunction

    function automatic rom_t build_rom(input kernel_mode_t km);
        rom_t t;
        for (int Ix = 0; Ix < TABLE_DEPTH; Ix++)
        begin
            t[Ix] = kernel_entry(km, 64'(Ix));
        end
        return t;
    endfunction

    localparam rom_t ROM_ALPHA = build_rom(KM_ALPHA);
    localparam rom_t ROM_EXP   = build_rom(KM_EXP);
    localparam rom_t ROM_DEXP  = build_rom(KM_DEXP);
    localparam rom_t ROM_DERIV = build_rom(KM_DERIV);

    logic signed [KERNEL_W-1:0] rom_data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unique case (mode)
                KM_ALPHA: rom_data_reg <= ROM_ALPHA[addr];
                KM_EXP:   rom_data_reg <= ROM_EXP[addr];
                KM_DEXP:  rom_data_reg <= ROM_DEXP[addr];
                KM_DERIV: rom_data_reg <= ROM_DERIV[addr];
                default:  rom_data_reg <= '0;
            endcase
        end
    end

    assign rom_data = rom_data_reg;

endmodule

// ----- rtl/core/skrd_accum.sv -----
// Saturating accumulator and result register.
module skrd_accum (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  skrd_pkg::s1_t                         s1,
    input  skrd_pkg::kernel_mode_t                mode,
    input  logic signed [skrd_pkg::KERNEL_W-1:0]  rom_data,
    output logic                                  s1_hold,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [skrd_pkg::RATE_W-1:0]    rate
);
    import skrd_pkg::*;

    logic signed [KERNEL_W-1:0] kernel_val;
    logic signed [RATE_W:0]     sum_wide;
    logic signed [RATE_W-1:0]   sum_sat;
    logic signed [RATE_W-1:0]   acc_val;
    logic                       fire;
    logic signed [RATE_W-1:0]   sum_reg;
    logic signed [RATE_W-1:0]   sum_next;
    logic signed [RATE_W-1:0]   rate_reg;
    logic signed [RATE_W-1:0]   rate_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    always_comb
    begin
        unique case (mode)
            KM_BOX:   kernel_val = BOX_Q16;
            KM_ALPHA,
            KM_EXP,
            KM_DEXP,
            KM_DERIV: kernel_val = s1.in_table ? rom_data : '0;
            default:  kernel_val = '0;
        endcase
    end

    assign sum_wide = {sum_reg[RATE_W-1], sum_reg} + (RATE_W + 1)'(kernel_val);

    always_comb
    begin
        if (sum_wide[RATE_W] != sum_wide[RATE_W-1])
            sum_sat = sum_wide[RATE_W] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[RATE_W-1:0];
    end

    assign acc_val = s1.count ? sum_sat : sum_reg;
    assign s1_hold = s1.last && out_valid_reg && out_stall;
    assign fire    = s1.valid && !s1_hold;

    always_comb
    begin
        sum_next       = sum_reg;
        rate_next      = rate_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            if (s1.last)
            begin
                sum_next       = '0;
                rate_next      = acc_val;
                out_valid_next = 1'b1;
            end
            else
            begin
                sum_next = acc_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg <= rate_next;
    end

    assign out_valid = out_valid_reg;
    assign rate      = rate_reg;

endmodule

// ----- rtl/core/spike_kernel_rate_decoder_core.sv -----
// Top level of the spike kernel rate decoder.
//
// Input channel (in_valid/in_stall) carries one spike beat: query_time,
// spike_time, spike_valid and last_spike. A spike whose delay lies within
// the window adds one kernel value to a saturating Q24.16 sum. A beat with
// last_spike set emits the sum, including its own spike, on the output
// channel (out_valid/out_stall, field rate) and clears the sum.
// Throughput: one beat per cycle while in_stall is low. A last beat passes
// from the front-stage register into the output register once that is free.
// The kernel table read is registered alongside the front-stage register.
// When the receiver stalls, the result register holds; non-last beats keep
// flowing into the sum, and in_stall rises only when a last beat meets a
// full, stalled result register.
// Configuration beats (cfg_valid/cfg_ready) write kernel_mode (index 0)
// and window (index 1); cfg_ready is always high. Write only while idle.
// Reset clears the sum and the result valid, selects the box kernel and
// sets the window to one second.
module spike_kernel_rate_decoder_core #(
    parameter int TABLE_DEPTH    = skrd_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_FRAC_BITS = skrd_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [skrd_pkg::TIME_W-1:0]         query_time,
    input  logic [skrd_pkg::TIME_W-1:0]         spike_time,
    input  logic                                spike_valid,
    input  logic                                last_spike,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [skrd_pkg::RATE_W-1:0]  rate,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [skrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [skrd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import skrd_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    kernel_mode_t               kernel_mode_reg;
    logic [WINDOW_W-1:0]        window_reg;
    logic                       s1_hold;
    logic [IDX_W-1:0]           rom_addr;
    logic                       rom_load;
    logic signed [KERNEL_W-1:0] rom_data;
    s1_t                        s1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg <= KM_BOX;
            window_reg      <= WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KERNEL_MODE: kernel_mode_reg <= kernel_mode_t'(cfg_data[2:0]);
                CFG_WINDOW:      window_reg      <= cfg_data[WINDOW_W-1:0];
                default:         window_reg      <= window_reg;
            endcase
        end
    end

    skrd_front #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .query_time  (query_time),
        .spike_time  (spike_time),
        .spike_valid (spike_valid),
        .last_spike  (last_spike),
        .window      (window_reg),
        .s1_hold     (s1_hold),
        .rom_addr    (rom_addr),
        .rom_load    (rom_load),
        .s1          (s1)
    );

    skrd_kernel_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .clk      (clk),
        .load     (rom_load),
        .mode     (kernel_mode_reg),
        .addr     (rom_addr),
        .rom_data (rom_data)
    );

    skrd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1),
        .mode      (kernel_mode_reg),
        .rom_data  (rom_data),
        .s1_hold   (s1_hold),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rate      (rate)
    );

endmodule

// ----- rtl/core/skrd_checker.sv -----
// Port-level checker for the spike kernel rate decoder, with its bind.
`include "assert_macros.svh"

module skrd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                last_spike,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [skrd_pkg::RATE_W-1:0]  rate
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(rate))
    `ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_NEXT(a_last_emits, clk, rst_n, in_valid && !in_stall && last_spike ##1 !out_valid, out_valid)

endmodule

bind spike_kernel_rate_decoder_core skrd_checker u_skrd_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the spike kernel rate decoder core.
module tb;
    import skrd_pkg::*;

    localparam longint unsigned TBL_N     = TABLE_DEPTH_DEF;
    localparam longint unsigned Q32_ONE   = 64'd4294967296;
    localparam longint unsigned Q32_MASK  = 64'hFFFF_FFFF;
    localparam longint unsigned Q32_EINV  = 64'd1580030169;
    localparam longint unsigned Q32_E     = 64'd11674931555;
    localparam longint unsigned Q32_NORM  = 64'd9090447472;
    localparam longint          ONE_Q16   = 65536;
    localparam logic [2:0]      MODE_RSVD_LO = 3'd5;
    localparam logic [2:0]      MODE_RSVD_HI = 3'd7;
    localparam int              PHASES    = 10;
    localparam int              PHASE_ITEMS = 100;
    localparam int              DRAIN_CYC = 4;
    localparam int              STALL_LIMIT = 2000;

    typedef struct {
        bit                       cfg;
        logic [2:0]               mode;
        logic [WINDOW_W-1:0]      win;
        logic [TIME_W-1:0]        qt;
        logic [TIME_W-1:0]        st;
        bit                       sv;
        bit                       last;
        bit                       known;
        logic signed [RATE_W-1:0] exp_rate;
    } spike_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [TIME_W-1:0]          query_time;
    logic [TIME_W-1:0]          spike_time;
    logic                       spike_valid;
    logic                       last_spike;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [RATE_W-1:0]   rate;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    longint                     kern_tbl [0:4][0:TABLE_DEPTH_DEF-1];
    logic [2:0]                 mode_cfg;
    logic [WINDOW_W-1:0]        win_cfg;
    longint                     rate_acc;
    logic signed [RATE_W-1:0]   rate_due_q [$];
    spike_row_t                 spike_tbl [$];

    bit                         idle_on = 1'b0;
    int                         stall_cnt = 0;
    int                         idle_cyc = 0;
    int                         n_items = 0;
    int                         n_results = 0;
    int                         n_cfg = 0;
    int                         n_errors = 0;

    spike_kernel_rate_decoder_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .query_time  (query_time),
        .spike_time  (spike_time),
        .spike_valid (spike_valid),
        .last_spike  (last_spike),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rate        (rate),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned q32_mul(input longint unsigned a, input longint unsigned b);
        longint unsigned ah, al, bh, bl;
        ah = a >> 32;
        al = a & Q32_MASK;
        bh = b >> 32;
        bl = b & Q32_MASK;
        return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    endfunction

    function automatic longint unsigned neg_exp_q32(input longint unsigned y);
        longint unsigned n, f, term, r, k;
        longint acc;
        n = y >> 32;
        f = y & Q32_MASK;
        term = Q32_ONE;
        acc = longint'(Q32_ONE);
        for (k = 1; k <= 20; k++)
        begin
            term = q32_mul(term, f) / k;
            if (k[0])
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        r = longint'(acc);
        while (n > 0 && r != 0)
        begin
            r = q32_mul(r, Q32_EINV);
            n--;
        end
        return r;
    endfunction

    function automatic longint q16_round(input longint v);
        longint w;
        w = v + 32768;
        if (w >= 0)
            return w >> 16;
        return -(((-w) + 65535) >> 16);
    endfunction

    function automatic longint kernel_entry(input logic [2:0] m, input longint unsigned idx);
        longint unsigned x10, e10, e40, pos, neg;
        longint v;
        x10 = ((64'd10 * idx) << 32) / TBL_N;
        e10 = neg_exp_q32(x10);
        e40 = neg_exp_q32(((64'd40 * idx) << 32) / TBL_N);
        if (m == KM_ALPHA)
            v = longint'(q32_mul(q32_mul(x10, e10), Q32_E));
        else if (m == KM_EXP)
            v = longint'(e10);
        else if (m == KM_DEXP)
            v = (e10 >= e40) ? longint'(q32_mul(e10 - e40, Q32_NORM)) : 0;
        else
        begin
            pos = 64'd40 * e40;
            neg = 64'd10 * e10;
            if (pos >= neg)
                v = longint'(q32_mul(pos - neg, Q32_NORM));
            else
                v = -longint'(q32_mul(neg - pos, Q32_NORM));
        end
        return q16_round(v);
    endfunction

    function automatic longint kernel_value(input logic [2:0] m, input logic [TIME_W-1:0] d);
        longint unsigned idx;
        if (m == KM_BOX)
            return ONE_Q16;
        if (m > KM_DERIV)
            return 0;
        idx = ({32'd0, d} * TBL_N) >> TIME_FRAC_BITS_DEF;
        if (idx >= TBL_N)
            return 0;
        return kern_tbl[m][idx];
    endfunction

    function automatic bit rate_predict(input logic [TIME_W-1:0] qt, input logic [TIME_W-1:0] st,
                                        input bit sv, input bit last,
                                        output logic signed [RATE_W-1:0] res);
        longint t;
        res = '0;
        if (sv && st <= qt && (qt - st) <= {8'd0, win_cfg})
        begin
            t = rate_acc + kernel_value(mode_cfg, qt - st);
            if (t > longint'(SUM_MAX))
                t = longint'(SUM_MAX);
            if (t < longint'(SUM_MIN))
                t = longint'(SUM_MIN);
            rate_acc = t;
        end
        if (!last)
            return 1'b0;
        res = rate_acc[RATE_W-1:0];
        rate_acc = 0;
        return 1'b1;
    endfunction

    task automatic add_row(input bit cfg, input logic [2:0] mode, input logic [WINDOW_W-1:0] win,
                           input logic [TIME_W-1:0] qt, input logic [TIME_W-1:0] st,
                           input bit sv, input bit last, input bit known,
                           input logic signed [RATE_W-1:0] exp_rate);
        spike_row_t row;
        row.cfg = cfg;
        row.mode = mode;
        row.win = win;
        row.qt = qt;
        row.st = st;
        row.sv = sv;
        row.last = last;
        row.known = known;
        row.exp_rate = exp_rate;
        spike_tbl.push_back(row);
    endtask

    task automatic send_spike(input logic [TIME_W-1:0] qt, input logic [TIME_W-1:0] st,
                              input bit sv, input bit last, input bit known,
                              input logic signed [RATE_W-1:0] typed);
        int gap;
        bit has;
        logic signed [RATE_W-1:0] res;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        query_time <= qt;
        spike_time <= st;
        spike_valid <= sv;
        last_spike <= last;
        do @(posedge clk); while (in_stall);
        n_items++;
        has = rate_predict(qt, st, sv, last, res);
        if (has)
            rate_due_q.push_back(known ? typed : res);
    endtask

    task automatic set_regs(input logic [2:0] mode, input logic [WINDOW_W-1:0] win);
        in_valid <= 1'b0;
        while (rate_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_KERNEL_MODE;
        cfg_data <= {{(CFG_DATA_W-3){1'b0}}, mode};
        do @(posedge clk); while (!cfg_ready);
        mode_cfg = mode;
        cfg_index <= CFG_WINDOW;
        cfg_data <= win;
        do @(posedge clk); while (!cfg_ready);
        win_cfg = win;
        cfg_valid <= 1'b0;
        n_cfg += 2;
    endtask

    always @(posedge clk)
    begin
        if (stall_cnt != 0)
        begin
            out_stall <= 1'b1;
            stall_cnt <= stall_cnt - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_cnt <= $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;

        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (rate_due_q.size() == 0)
            begin
                $display("%0t rate beat %0d arrived with no pending result", $time, rate);
                n_errors++;
            end
            else
            begin
                if (rate !== rate_due_q[0])
                begin
                    $display("%0t rate mismatch: expected %0d, actual %0d",
                             $time, rate_due_q[0], rate);
                    n_errors++;
                end
                void'(rate_due_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cyc <= 0;
        else
        begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int ph, cnt, len, i, kind, span, wsel;
        logic [2:0] mode;
        logic [WINDOW_W-1:0] win;
        logic [TIME_W-1:0] qt, st;
        bit sv, last;

        rst_n = 1'b0;
        in_valid = 1'b0;
        query_time = '0;
        spike_time = '0;
        spike_valid = 1'b0;
        last_spike = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KERNEL_MODE;
        cfg_data = '0;

        for (int m = KM_ALPHA; m <= KM_DERIV; m++)
            for (int j = 0; j < TABLE_DEPTH_DEF; j++)
                kern_tbl[m][j] = kernel_entry(m[2:0], longint'(j));
        for (int j = 0; j < TABLE_DEPTH_DEF; j++)
            kern_tbl[KM_BOX][j] = ONE_Q16;
        mode_cfg = KM_BOX;
        win_cfg = WINDOW_RESET;
        rate_acc = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(0, KM_BOX, WINDOW_RESET, 32'h0000_1000, 32'h0000_1000, 0, 1, 1, 0);
        add_row(0, KM_BOX, WINDOW_RESET, 32'h0000_0000, 32'h0000_0000, 1, 1, 1, 65536);
        add_row(0, KM_BOX, WINDOW_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 65536);
        add_row(0, KM_BOX, WINDOW_RESET, 32'hFFFF_FFFF, 32'hFFFE_FFFF, 1, 1, 1, 65536);
        add_row(0, KM_BOX, WINDOW_RESET, 32'hFFFF_FFFF, 32'hFFFE_FFFE, 1, 1, 1, 0);
        add_row(0, KM_BOX, WINDOW_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 1, 0);
        add_row(0, KM_BOX, WINDOW_RESET, 32'h1234_5678, 32'h1234_5678, 1, 0, 0, 0);
        add_row(0, KM_BOX, WINDOW_RESET, 32'h1234_5678, 32'h1234_5614, 1, 1, 1, 131072);
        add_row(0, KM_BOX, WINDOW_RESET, 32'h5555_AAAA, 32'h5555_AAAA, 1, 0, 0, 0);
        add_row(0, KM_BOX, WINDOW_RESET, 32'h5555_AAAA, 32'h5555_AAAA, 0, 1, 1, 65536);
        add_row(1, KM_BOX, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0000, 1, 1, 1, 65536);
        add_row(1, KM_EXP, WINDOW_RESET, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, 65536);
        add_row(0, KM_EXP, WINDOW_RESET, 32'h8000_FFFF, 32'h8000_0000, 1, 1, 0, 0);
        add_row(1, KM_EXP, 24'hFF_FFFF, 32'h0002_0000, 32'h0001_0000, 1, 1, 1, 0);
        add_row(1, KM_ALPHA, WINDOW_RESET, 32'hAAAA_5555, 32'hAAAA_5555, 1, 1, 1, 0);
        add_row(0, KM_ALPHA, WINDOW_RESET, 32'h0000_199A, 32'h0000_0000, 1, 1, 0, 0);
        add_row(1, KM_DEXP, WINDOW_RESET, 32'h0F0F_0F0F, 32'h0F0F_0F0F, 1, 1, 1, 0);
        add_row(0, KM_DEXP, WINDOW_RESET, 32'h0000_0666, 32'h0000_0000, 1, 1, 0, 0);
        add_row(1, KM_DERIV, WINDOW_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 0, 0);
        add_row(0, KM_DERIV, WINDOW_RESET, 32'h0000_4000, 32'h0000_0000, 1, 1, 0, 0);
        add_row(1, MODE_RSVD_HI, 24'hFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1, 1, 1, 0);
        add_row(1, MODE_RSVD_LO, 24'hFF_FFFF, 32'h0000_0010, 32'h0000_0000, 1, 1, 1, 0);
        add_row(1, KM_BOX, 24'h00_0000, 32'h0000_0100, 32'h0000_0100, 1, 1, 1, 65536);
        add_row(0, KM_BOX, 24'h00_0000, 32'h0000_0101, 32'h0000_0100, 1, 1, 1, 0);

        idle_on = 1'b1;
        foreach (spike_tbl[r])
        begin
            if (spike_tbl[r].cfg)
                set_regs(spike_tbl[r].mode, spike_tbl[r].win);
            send_spike(spike_tbl[r].qt, spike_tbl[r].st, spike_tbl[r].sv, spike_tbl[r].last,
                       spike_tbl[r].known, spike_tbl[r].exp_rate);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            mode = (ph < 5) ? ph[2:0] : 3'($urandom_range(0, 4));
            wsel = $urandom_range(0, 5);
            case (wsel)
                0: win = 24'h00_0000;
                1: win = WINDOW_RESET;
                2: win = 24'hFF_FFFF;
                3: win = 24'($urandom_range(1, 65535));
                4: win = 24'($urandom_range(65536, 131072));
                default: win = 24'($urandom);
            endcase
            set_regs(mode, win);
            idle_on = (ph < PHASES - 2) && (ph != 3);
            cnt = 0;
            while (cnt < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                qt = $urandom;
                for (i = 0; i < len; i++)
                begin
                    kind = $urandom_range(0, 19);
                    sv = 1'b1;
                    if (kind < 14)
                    begin
                        if (win < 70000 || $urandom_range(0, 3) == 0)
                            span = win;
                        else
                            span = 70000;
                        st = qt - 32'($urandom_range(0, span));
                    end
                    else if (kind == 14)
                        st = qt + 32'($urandom_range(1, 100));
                    else if (kind == 15)
                        st = qt - {8'd0, win} - 32'($urandom_range(1, 1000));
                    else if (kind < 18)
                        st = $urandom;
                    else
                    begin
                        sv = 1'b0;
                        st = $urandom;
                    end
                    last = (i == len - 1) && ($urandom_range(0, 19) != 0);
                    if ($urandom_range(0, 29) == 0)
                        last = 1'b1;
                    send_spike(qt, st, sv, last, 1'b0, '0);
                    cnt++;
                end
            end
        end

        in_valid <= 1'b0;
        while (rate_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("covered %0d spike beats and %0d register writes: all kernels, reserved modes,",
                 n_items, n_cfg);
        $display("window extremes and stall bursts; %0d rate results checked, %0d mismatches",
                 n_results, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/skrd_pkg.sv
rtl/core/skrd_front.sv
rtl/core/skrd_kernel_rom.sv
rtl/core/skrd_accum.sv
rtl/core/spike_kernel_rate_decoder_core.sv
rtl/core/skrd_checker.sv
verif/tb.sv
